// File: sv/rpec_pkg.sv
// Shared constants and types for the rank priority eviction cache.
package rpec_pkg;

    localparam int ENTRIES  = 16;
    localparam int KEY_W    = 32;
    localparam int VALUE_W  = 32;
    localparam int RANK_W   = 16;
    localparam int CAP_W    = 5;
    localparam int IDX_W    = $clog2(ENTRIES);
    localparam int CNT_W    = $clog2(ENTRIES + 1);
    localparam int CMP_W    = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
    localparam logic             REG_IDX_CAPACITY = 1'b0;
    localparam logic             OP_LOOKUP = 1'b0;
    localparam logic             OP_INSERT = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [RANK_W-1:0] rank;
    } req_t;

    typedef struct packed {
        logic               found;
        logic [IDX_W-1:0]   found_idx;
        logic [VALUE_W-1:0] found_value;
        logic               free_any;
        logic [IDX_W-1:0]   free_idx;
        logic [CNT_W-1:0]   count;
        logic               vic_any;
        logic [IDX_W-1:0]   vic_idx;
        logic [RANK_W-1:0]  vic_rank;
        logic [KEY_W-1:0]   vic_key;
    } wave_t;

    typedef struct packed {
        logic               en;
        logic [IDX_W-1:0]   idx;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
        logic [RANK_W-1:0]  rank;
    } wr_t;

endpackage

// File: sv/rpec_cell.sv
// One slot of the store: holds an entry and folds it into the search wave.
module rpec_cell (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [rpec_pkg::IDX_W-1:0]    cell_idx,
    input  rpec_pkg::req_t                req,
    input  rpec_pkg::wave_t               wave_in,
    input  rpec_pkg::wr_t                 wr,
    output rpec_pkg::wave_t               wave_out
);

    logic                            valid_reg;
    logic [rpec_pkg::KEY_W-1:0]      key_reg;
    logic [rpec_pkg::VALUE_W-1:0]    value_reg;
    logic [rpec_pkg::RANK_W-1:0]     rank_reg;
    rpec_pkg::wave_t                 wave_reg;
    rpec_pkg::wave_t                 wave_next;
    logic                            wr_hit;

    assign wr_hit   = wr.en && (wr.idx == cell_idx);
    assign wave_out = wave_reg;

    always_comb begin
        wave_next = wave_in;
        if (valid_reg) begin
            wave_next.count = wave_in.count + rpec_pkg::CNT_W'(1);
            if (!wave_in.found && key_reg == req.key) begin
                wave_next.found       = 1'b1;
                wave_next.found_idx   = cell_idx;
                wave_next.found_value = value_reg;
            end
            if (!wave_in.vic_any || rank_reg > wave_in.vic_rank) begin
                wave_next.vic_any  = 1'b1;
                wave_next.vic_idx  = cell_idx;
                wave_next.vic_rank = rank_reg;
                wave_next.vic_key  = key_reg;
            end
        end else if (!wave_in.free_any) begin
            wave_next.free_any = 1'b1;
            wave_next.free_idx = cell_idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (wr_hit) begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        wave_reg <= wave_next;
        if (wr_hit) begin
            key_reg   <= wr.key;
            value_reg <= wr.value;
            rank_reg  <= wr.rank;
        end
    end

endmodule

// File: sv/rank_priority_eviction_cache_top.sv
// Top level: fully associative key/value cache with worst-rank eviction.
//
// Input channel s_*: op (0 lookup, 1 insert), key, data_value, priority_rank.
// Result channel m_*: hit, read_value, evicted, evicted_key; one result per item.
// Config: APB-style port, register 0 (byte address 0) is active_capacity.
//
// The slots form a row of cells. A search wave carrying match, free slot,
// fill count and worst-rank victim moves one cell per cycle through the
// registered cells; after the last cell a commit step updates the store and
// loads the result register. An item is accepted only while the row is idle,
// so a new item is not taken until the previous one has committed.
//
// Reset (aresetn low, synchronous) empties every slot and sets
// active_capacity to 16. A stalled result register (m_valid high, m_ready low)
// holds its item; a following item may be accepted and searched, but its
// commit waits until the result register is free.
module rank_priority_eviction_cache_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_op,
    input  logic [rpec_pkg::KEY_W-1:0]      s_key,
    input  logic [rpec_pkg::VALUE_W-1:0]    s_data_value,
    input  logic [rpec_pkg::RANK_W-1:0]     s_priority_rank,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_hit,
    output logic [rpec_pkg::VALUE_W-1:0]    m_read_value,
    output logic                            m_evicted,
    output logic [rpec_pkg::KEY_W-1:0]      m_evicted_key,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rpec_pkg::ADDR_W-1:0]     paddr,
    input  logic [rpec_pkg::DATA_W-1:0]     pwdata,
    output logic [rpec_pkg::DATA_W-1:0]     prdata,
    output logic                            pready
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;
    localparam logic [rpec_pkg::IDX_W-1:0] LAST_IDX = rpec_pkg::IDX_W'(rpec_pkg::ENTRIES - 1);

    logic [1:0]                       state_reg, state_next;
    logic [rpec_pkg::IDX_W-1:0]       scan_cnt_reg, scan_cnt_next;
    logic [rpec_pkg::CAP_W-1:0]       cap_reg;
    logic                             op_reg;
    logic [rpec_pkg::VALUE_W-1:0]     value_reg;
    rpec_pkg::req_t                   req_reg;

    logic                             m_valid_reg;
    logic                             m_hit_reg, m_hit_next;
    logic [rpec_pkg::VALUE_W-1:0]     m_read_value_reg, m_read_value_next;
    logic                             m_evicted_reg, m_evicted_next;
    logic [rpec_pkg::KEY_W-1:0]       m_evicted_key_reg, m_evicted_key_next;

    rpec_pkg::wave_t                  wave [rpec_pkg::ENTRIES+1];
    rpec_pkg::wave_t                  last;
    rpec_pkg::wr_t                    wr;
    logic                             in_fire;
    logic                             commit;
    logic                             cfg_write;
    logic [rpec_pkg::CMP_W-1:0]       cap_ext, used_cap;
    logic                             has_room;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == rpec_pkg::REG_IDX_CAPACITY)
                     ? rpec_pkg::DATA_W'(cap_reg) : '0;

    assign s_ready = (state_reg == ST_IDLE);
    assign in_fire = s_valid && s_ready;
    assign commit  = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    assign wave[0] = '0;
    assign last    = wave[rpec_pkg::ENTRIES];

    for (genvar g = 0; g < rpec_pkg::ENTRIES; g++) begin : g_cell
        rpec_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_idx (rpec_pkg::IDX_W'(g)),
            .req      (req_reg),
            .wave_in  (wave[g]),
            .wr       (wr),
            .wave_out (wave[g+1])
        );
    end

    always_comb begin
        cap_ext = rpec_pkg::CMP_W'(cap_reg);
        if (cap_reg == '0) begin
            used_cap = rpec_pkg::CMP_W'(1);
        end else if (cap_ext > rpec_pkg::CMP_W'(rpec_pkg::ENTRIES)) begin
            used_cap = rpec_pkg::CMP_W'(rpec_pkg::ENTRIES);
        end else begin
            used_cap = cap_ext;
        end
        has_room = (rpec_pkg::CMP_W'(last.count) < used_cap) && last.free_any;
    end

    always_comb begin
        m_hit_next         = 1'b0;
        m_read_value_next  = '0;
        m_evicted_next     = 1'b0;
        m_evicted_key_next = '0;
        wr.en              = 1'b0;
        wr.idx             = last.found_idx;
        wr.key             = req_reg.key;
        wr.value           = value_reg;
        wr.rank            = req_reg.rank;
        if (op_reg == rpec_pkg::OP_LOOKUP) begin
            m_hit_next = last.found;
            if (last.found) begin
                m_read_value_next = last.found_value;
            end
        end else if (last.found) begin
            m_hit_next = 1'b1;
            wr.en      = commit;
        end else if (has_room) begin
            wr.en  = commit;
            wr.idx = last.free_idx;
        end else begin
            m_evicted_next = 1'b1;
            if (!last.vic_any || req_reg.rank > last.vic_rank) begin
                m_evicted_key_next = req_reg.key;
            end else begin
                m_evicted_key_next = last.vic_key;
                wr.en              = commit;
                wr.idx             = last.vic_idx;
            end
        end
    end

    always_comb begin
        state_next    = state_reg;
        scan_cnt_next = scan_cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    state_next    = ST_SCAN;
                    scan_cnt_next = '0;
                end
            end
            ST_SCAN: begin
                if (scan_cnt_reg == LAST_IDX) begin
                    state_next = ST_DONE;
                end else begin
                    scan_cnt_next = scan_cnt_reg + rpec_pkg::IDX_W'(1);
                end
            end
            ST_DONE: begin
                if (commit) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            scan_cnt_reg <= '0;
            cap_reg      <= rpec_pkg::CAP_RESET;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            scan_cnt_reg <= scan_cnt_next;
            if (cfg_write && paddr[2] == rpec_pkg::REG_IDX_CAPACITY) begin
                cap_reg <= pwdata[rpec_pkg::CAP_W-1:0];
            end
            if (commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            op_reg       <= s_op;
            value_reg    <= s_data_value;
            req_reg.key  <= s_key;
            req_reg.rank <= s_priority_rank;
        end
        if (commit) begin
            m_hit_reg         <= m_hit_next;
            m_read_value_reg  <= m_read_value_next;
            m_evicted_reg     <= m_evicted_next;
            m_evicted_key_reg <= m_evicted_key_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_hit         = m_hit_reg;
    assign m_read_value  = m_read_value_reg;
    assign m_evicted     = m_evicted_reg;
    assign m_evicted_key = m_evicted_key_reg;

`ifndef NO_ASSERTIONS
    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result raised outside commit");

    a_write_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        wr.en |-> (state_reg == ST_DONE) && (!m_valid_reg || m_ready))
        else $error("slot written while result register busy");

    a_victim_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && last.vic_any) |-> last.count != '0)
        else $error("victim reported with empty store");
`endif

endmodule
